// File: sv/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; imported by hsv2rgb_chan and hsv_to_rgb_converter.
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W    = 16;
    localparam int FRAC_W   = 9;
    localparam int CH_W     = 8;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 24;

    // hue sector width in 1/16 degree
    localparam logic [10:0] HUE_SECTOR  = 11'd960;
    // ceil(2^16 / 15): floor(x / 15) for x below 1024
    localparam logic [12:0] DIV15_RECIP = 13'd4370;
    // ceil(2^8 / 6): floor(q / 6) for q below 69
    localparam logic [12:0] DIV6_RECIP  = 13'd43;
    // y / 15 reaches 256 from here on
    localparam logic [12:0] Y_SAT       = 13'd3840;

    // per-channel term select
    localparam logic [1:0] SEL_ZERO   = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_CHROMA = 2'd2;

    typedef struct packed {
        logic en_sum;
        logic en_out;
    } chan_ctrl_t;

endpackage

`default_nettype wire

// File: sv/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter, top level: hue split, chroma and offset stages.
// Depends on hsv2rgb_pkg and hsv2rgb_chan.
//
//  channel | dir | tdata fields (low bit up)                  | tuser/tlast
//  s_axis  | in  | hue[15:0] saturation[24:16] brightness[33:25] | none
//  m_axis  | out | red[7:0] green[15:8] blue[23:16]             | none
//
// Five register stages, one pixel per cycle while the output is not held.
// Each stage's valid bit travels with its data; a stage loads when it is
// empty or the stage after it moves, so bubbles close up under a stall.
// A stalled result holds in the output stage; nothing is lost or repeated.
// aresetn clears the valid bits only.
`default_nettype none

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_DW-1:0]  s_axis_tdata,   // hue, saturation, brightness
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_DW-1:0]      m_axis_tdata    // red, green, blue
);

    logic [5:1] vld_reg;
    logic [5:1] en;

    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] bri;

    // stage 1
    logic [22:0]       q_prod;
    logic [17:0]       sv_next;
    logic [6:0]        q1_reg;
    logic [HUE_W-1:0]  hue1_reg;
    logic [17:0]       sv1_reg;
    logic [FRAC_W-1:0] bri1_reg;

    // stage 2
    logic [12:0]        d_prod;
    logic [6:0]         d6;
    logic [6:0]         sect_full;
    logic [16:0]        q960;
    logic [16:0]        pos_full;
    logic signed [18:0] a_next;
    logic [9:0]         pos2_reg;
    logic [2:0]         sect2_reg;
    logic [17:0]        sv2_reg;
    logic signed [18:0] a2_reg;

    // stage 3
    logic [10:0]        p_frac;
    logic [28:0]        sec_prod;
    logic [27:0]        chroma_next;
    logic signed [29:0] a960_next;
    logic [27:0]        second3_reg;
    logic [27:0]        chroma3_reg;
    logic signed [29:0] a960_3_reg;
    logic [2:0]         sect3_reg;

    logic [1:0] sel_r;
    logic [1:0] sel_g;
    logic [1:0] sel_b;
    chan_ctrl_t ctrl;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    assign hue = s_axis_tdata[15:0];
    assign sat = s_axis_tdata[24:16];
    assign bri = s_axis_tdata[33:25];

    assign en[5] = !vld_reg[5] || m_axis_tready;
    assign en[4] = !vld_reg[4] || en[5];
    assign en[3] = !vld_reg[3] || en[4];
    assign en[2] = !vld_reg[2] || en[3];
    assign en[1] = !vld_reg[1] || en[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[1]) vld_reg[1] <= s_axis_tvalid;
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
            if (en[4]) vld_reg[4] <= vld_reg[3];
            if (en[5]) vld_reg[5] <= vld_reg[4];
        end
    end

    // stage 1: sector count hue / 960 = (hue >> 6) / 15, and s * v
    assign q_prod  = {3'b0, hue[15:6]} * {10'b0, DIV15_RECIP};
    assign sv_next = {9'b0, sat} * {9'b0, bri};

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            q1_reg   <= q_prod[22:16];
            hue1_reg <= hue;
            sv1_reg  <= sv_next;
            bri1_reg <= bri;
        end
    end

    // stage 2: sector = q mod 6, position = hue - 960 q, offset = 256 v - s v
    assign d_prod    = {6'b0, q1_reg} * DIV6_RECIP;
    assign d6        = {3'b0, d_prod[11:8]} * 7'd6;
    assign sect_full = q1_reg - d6;
    assign q960      = {10'b0, q1_reg} * {6'b0, HUE_SECTOR};
    assign pos_full  = {1'b0, hue1_reg} - q960;
    assign a_next    = $signed({2'b0, bri1_reg, 8'b0}) - $signed({1'b0, sv1_reg});

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            pos2_reg  <= pos_full[9:0];
            sect2_reg <= sect_full[2:0];
            sv2_reg   <= sv1_reg;
            a2_reg    <= a_next;
        end
    end

    // stage 3: secondary, chroma and offset, all scaled by 960
    assign p_frac      = sect2_reg[0] ? (HUE_SECTOR - {1'b0, pos2_reg}) : {1'b0, pos2_reg};
    assign sec_prod    = {11'b0, sv2_reg} * {18'b0, p_frac};
    assign chroma_next = {10'b0, sv2_reg} * {17'b0, HUE_SECTOR};
    assign a960_next   = $signed({{11{a2_reg[18]}}, a2_reg}) * $signed({19'b0, HUE_SECTOR});

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            second3_reg <= sec_prod[27:0];
            chroma3_reg <= chroma_next;
            a960_3_reg  <= a960_next;
            sect3_reg   <= sect2_reg;
        end
    end

    always_comb begin
        case (sect3_reg)
            3'd0: begin
                sel_r = SEL_CHROMA; sel_g = SEL_SECOND; sel_b = SEL_ZERO;
            end
            3'd1: begin
                sel_r = SEL_SECOND; sel_g = SEL_CHROMA; sel_b = SEL_ZERO;
            end
            3'd2: begin
                sel_r = SEL_ZERO;   sel_g = SEL_CHROMA; sel_b = SEL_SECOND;
            end
            3'd3: begin
                sel_r = SEL_ZERO;   sel_g = SEL_SECOND; sel_b = SEL_CHROMA;
            end
            3'd4: begin
                sel_r = SEL_SECOND; sel_g = SEL_ZERO;   sel_b = SEL_CHROMA;
            end
            default: begin
                sel_r = SEL_CHROMA; sel_g = SEL_ZERO;   sel_b = SEL_SECOND;
            end
        endcase
    end

    // stages 4 and 5
    assign ctrl.en_sum = en[4];
    assign ctrl.en_out = en[5];

    hsv2rgb_chan u_chan_r (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .sel       (sel_r),
        .offset960 (a960_3_reg),
        .second    (second3_reg),
        .chroma    (chroma3_reg),
        .level     (red)
    );

    hsv2rgb_chan u_chan_g (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .sel       (sel_g),
        .offset960 (a960_3_reg),
        .second    (second3_reg),
        .chroma    (chroma3_reg),
        .level     (green)
    );

    hsv2rgb_chan u_chan_b (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .sel       (sel_b),
        .offset960 (a960_3_reg),
        .second    (second3_reg),
        .chroma    (chroma3_reg),
        .level     (blue)
    );

    assign s_axis_tready = en[1];
    assign m_axis_tvalid = vld_reg[5];
    assign m_axis_tdata  = {blue, green, red};

    // input stalls only when every stage is full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (&vld_reg) && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // with the output never stalled, output valid follows accepted input transfers with no hold and no extra result
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(m_axis_tready, 1) && $past(m_axis_tready, 2) && $past(m_axis_tready, 3)
         && $past(m_axis_tready, 4) && $past(m_axis_tready, 5)
         && $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3)
         && $past(aresetn, 4) && $past(aresetn, 5))
        |-> m_axis_tvalid == $past(s_axis_tvalid && s_axis_tready, 5))
        else $error("pipeline latency or occupancy mismatch");

    // a held result may not be replaced by a stage behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5] && !m_axis_tready |-> !en[4] || !vld_reg[4])
        else $error("stage four advanced into a held output");

endmodule

`default_nettype wire

// File: sv/hsv2rgb_chan.sv
// One color channel: offset add, scale by 255, divide by 15, saturate.
// Two pipeline stages; depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_chan
    import hsv2rgb_pkg::*;
(
    input  wire logic               aclk,
    input  wire chan_ctrl_t         ctrl,
    input  wire logic [1:0]         sel,
    input  wire logic signed [29:0] offset960,
    input  wire logic [27:0]        second,
    input  wire logic [27:0]        chroma,
    output logic [CH_W-1:0]         level
);

    logic [27:0]        term;
    logic signed [30:0] n_sum;
    logic [34:0]        n_scaled;
    logic [12:0]        y_next;
    logic [12:0]        y_reg;
    logic [25:0]        y_recip;
    logic [CH_W-1:0]    level_next;
    logic [CH_W-1:0]    level_reg;

    always_comb begin
        case (sel)
            SEL_SECOND: term = second;
            SEL_CHROMA: term = chroma;
            default:    term = 28'd0;
        endcase
    end

    assign n_sum    = $signed({offset960[29], offset960}) + $signed({3'b0, term});
    assign n_scaled = {8'b0, n_sum[26:0]} * 35'd255;
    assign y_next   = (n_sum <= 31'sd0) ? 13'd0 : n_scaled[34:22];

    assign y_recip    = {13'b0, y_reg} * {13'b0, DIV15_RECIP};
    assign level_next = (y_reg >= Y_SAT) ? 8'd255 : y_recip[23:16];

    always_ff @(posedge aclk) begin
        if (ctrl.en_sum) begin
            y_reg <= y_next;
        end
        if (ctrl.en_out) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire
